### sv/svt_pkg.sv
// Shared types and codes for the sorted value table.
// Used by svt_ctrl, svt_datapath and sorted_value_table_top; no dependencies.
`default_nettype none

package svt_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_DUMP   = 2'd3
  } req_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic apply;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic dump_last;
  } stat_t;

endpackage

`default_nettype wire

### sv/svt_ctrl.sv
// Controller for the sorted value table: request handshake, dump sequencing,
// output valid. Depends on svt_pkg.
`default_nettype none

module svt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_req_type,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire svt_pkg::stat_t status,
  output svt_pkg::cmd_t      cmd,
  output logic               dumping
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    in_ready  = (state_r == S_IDLE) && out_free;
    accept    = in_valid && in_ready;
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if ((svt_pkg::req_t'(in_req_type) == svt_pkg::REQ_DUMP) && !status.empty) begin
            state_nxt = S_DUMP;
          end else begin
            cmd.apply = 1'b1;
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (status.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.apply || cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign dumping   = (state_r == S_DUMP);

endmodule

`default_nettype wire

### sv/svt_datapath.sv
// Datapath for the sorted value table: row of compare-and-shift cells,
// entry count, dump position and result register. Depends on svt_pkg.
`default_nettype none

module svt_datapath #(
  parameter int CAPACITY = 32,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire svt_pkg::cmd_t      cmd,
  input  wire logic [1:0]         in_req_type,
  input  wire logic signed [31:0] in_value,
  output svt_pkg::stat_t          status,
  output logic [1:0]              out_status,
  output logic                    out_found,
  output logic signed [31:0]      out_value,
  output logic                    out_last,
  output logic [CW-1:0]           entry_count
);

  logic signed [31:0] ent_r [CAPACITY];
  logic signed [31:0] ins_v [CAPACITY];
  logic signed [31:0] del_v [CAPACITY];
  logic signed [31:0] rot_v [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       dump_idx_r, dump_idx_nxt;
  logic [CW-1:0]       count_m1;
  logic                hit;
  svt_pkg::req_t       req;

  always_comb begin
    req      = svt_pkg::req_t'(in_req_type);
    count_m1 = count_r - CW'(1);
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CW'(i) < count_r) && (ent_r[i] < in_value);
      eq[i] = (CW'(i) < count_r) && (ent_r[i] == in_value);
    end
    hit = |eq;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lt[i]) begin
        ins_v[i] = ent_r[i];
      end else if (i == 0) begin
        ins_v[i] = in_value;
      end else if (lt[i-1]) begin
        ins_v[i] = in_value;
      end else begin
        ins_v[i] = ent_r[i-1];
      end
      if (lt[i] || (i == CAPACITY - 1)) begin
        del_v[i] = ent_r[i];
      end else begin
        del_v[i] = ent_r[i+1];
      end
      if ((CW'(i) == count_m1) || (i == CAPACITY - 1)) begin
        rot_v[i] = ent_r[0];
      end else begin
        rot_v[i] = ent_r[i+1];
      end
    end
    status.empty     = (count_r == '0);
    status.full      = (count_r == CW'(CAPACITY));
    status.dump_last = (dump_idx_r == count_m1);
  end

  always_comb begin
    count_nxt    = count_r;
    dump_idx_nxt = dump_idx_r;
    if (cmd.apply) begin
      if ((req == svt_pkg::REQ_INSERT) && !status.full) begin
        count_nxt = count_r + CW'(1);
      end else if ((req == svt_pkg::REQ_DELETE) && hit) begin
        count_nxt = count_m1;
      end
    end
    if (cmd.emit) begin
      dump_idx_nxt = status.dump_last ? '0 : dump_idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      dump_idx_r <= '0;
    end else begin
      count_r    <= count_nxt;
      dump_idx_r <= dump_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && (req == svt_pkg::REQ_INSERT) && !status.full) begin
      ent_r <= ins_v;
    end else if (cmd.apply && (req == svt_pkg::REQ_DELETE) && hit) begin
      ent_r <= del_v;
    end else if (cmd.emit) begin
      ent_r <= rot_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= svt_pkg::ST_OK;
      out_found  <= 1'b0;
      out_value  <= ent_r[0];
      out_last   <= status.dump_last;
    end else if (cmd.apply) begin
      out_value <= '0;
      out_last  <= 1'b1;
      out_found <= 1'b0;
      case (req)
        svt_pkg::REQ_INSERT: begin
          out_status <= status.full ? svt_pkg::ST_FULL : svt_pkg::ST_OK;
        end
        svt_pkg::REQ_DELETE: begin
          if (status.empty) begin
            out_status <= svt_pkg::ST_EMPTY;
          end else if (hit) begin
            out_status <= svt_pkg::ST_OK;
            out_found  <= 1'b1;
          end else begin
            out_status <= svt_pkg::ST_NOTFOUND;
          end
        end
        svt_pkg::REQ_LOOKUP: begin
          out_status <= hit ? svt_pkg::ST_OK : svt_pkg::ST_NOTFOUND;
          out_found  <= hit;
        end
        default: begin
          out_status <= svt_pkg::ST_EMPTY;
        end
      endcase
    end
  end

  assign entry_count = count_r;

endmodule

`default_nettype wire

### sv/sorted_value_table_top.sv
// Sorted value table: ascending multiset of signed 32-bit values.
// Insert, delete and lookup are handled in the compare-and-shift cell row;
// the result is registered and the next request is taken once it is free.
// A dump streams N>0 entries by rotating the row, one a cycle unless stalled.
// Reset (rst_n low, synchronous) empties the table; entries are not cleared.
`default_nettype none

module sorted_value_table_top #(
  parameter int CAPACITY = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_req_type,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic                    out_found,
  output logic signed [31:0]      out_value,
  output logic                    out_last
);

  localparam int CW = $clog2(CAPACITY + 1);

  svt_pkg::cmd_t  cmd;
  svt_pkg::stat_t status;
  logic [CW-1:0]  entry_count;
  logic           dumping;

  svt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .cmd         (cmd),
    .dumping     (dumping)
  );

  svt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .status      (status),
    .out_status  (out_status),
    .out_found   (out_found),
    .out_value   (out_value),
    .out_last    (out_last),
    .entry_count (entry_count)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_req_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    dumping |-> !in_ready)
    else $error("request taken during dump");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_req_type == svt_pkg::REQ_INSERT) && !status.full)
    |=> (entry_count == $past(entry_count) + CW'(1)))
    else $error("insert did not grow the table");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.apply && cmd.emit))
    else $error("apply and emit together");

endmodule

`default_nettype wire
